>>> rtl/core/bpt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_pkg
// shared widths, register indexes and types of the barometric compensation
// ----------------------------------------------------------------------------
package bpt_pkg;

	localparam int RAW_W     = 24;
	localparam int CAL_W     = 16;
	localparam int TEMP_W    = 19;
	localparam int PRES_W    = 32;
	localparam int CFG_IDX_W = 3;
	localparam int OFF_W     = 37;
	localparam int SENS_W    = 36;

	// calibration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENS     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFF      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TC  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TC   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TREF     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_TEMPSENS = 3'd5;

	typedef struct packed {
		logic [CAL_W-1:0] sens;
		logic [CAL_W-1:0] off;
		logic [CAL_W-1:0] sens_tc;
		logic [CAL_W-1:0] off_tc;
		logic [CAL_W-1:0] tref;
		logic [CAL_W-1:0] tempsens;
	} cal_t;

	// hand-off from the coefficient stages to the pressure stages
	typedef struct packed {
		logic                     valid;
		logic [RAW_W-1:0]         raw_pressure;
		logic signed [TEMP_W-1:0] temperature;
		logic signed [OFF_W-1:0]  off;
		logic signed [SENS_W-1:0] sens;
	} coef_t;

endpackage
`default_nettype wire

>>> rtl/core/bpt_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_if
// valid/ready channels of the barometric compensation block
// ----------------------------------------------------------------------------
interface bpt_conv_if;
	logic                      valid;
	logic                      ready;
	logic [bpt_pkg::RAW_W-1:0] raw_pressure;
	logic [bpt_pkg::RAW_W-1:0] raw_temperature;

	modport source (output valid, output raw_pressure, output raw_temperature, input ready);
	modport sink (input valid, input raw_pressure, input raw_temperature, output ready);
endinterface

interface bpt_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [bpt_pkg::TEMP_W-1:0] temperature;
	logic signed [bpt_pkg::PRES_W-1:0] pressure;

	modport source (output valid, output temperature, output pressure, input ready);
	modport sink (input valid, input temperature, input pressure, output ready);
endinterface

interface bpt_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [bpt_pkg::CFG_IDX_W-1:0] index;
	logic [bpt_pkg::CAL_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/bpt_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_cfg_regs
// six calibration words, written through the configuration channel
// ----------------------------------------------------------------------------
module bpt_cfg_regs (
	input  logic           clk,
	input  logic           arst_n,
	bpt_cfg_if.sink        cfg,
	output bpt_pkg::cal_t  cal
);
	import bpt_pkg::*;

	cal_t cal_q;

	assign cfg.ready = 1'b1;
	assign cal       = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_SENS:     cal_q.sens     <= cfg.data;
				REG_OFF:      cal_q.off      <= cfg.data;
				REG_SENS_TC:  cal_q.sens_tc  <= cfg.data;
				REG_OFF_TC:   cal_q.off_tc   <= cfg.data;
				REG_TREF:     cal_q.tref     <= cfg.data;
				REG_TEMPSENS: cal_q.tempsens <= cfg.data;
				default: begin
					// unknown index, request dropped
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/bpt_coeff_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_coeff_pipe
// stages 1 to 3: temperature difference, coefficient products, temperature,
// offset and sensitivity
// ----------------------------------------------------------------------------
module bpt_coeff_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        in_valid,
	input  logic [bpt_pkg::RAW_W-1:0]   raw_pressure,
	input  logic [bpt_pkg::RAW_W-1:0]   raw_temperature,
	input  bpt_pkg::cal_t               cal,
	output bpt_pkg::coef_t              coef
);
	import bpt_pkg::*;

	localparam logic [41:0] TEMP_RND = 42'h0000_07F_FFFF;
	localparam logic [41:0] OFF_RND  = 42'd63;
	localparam logic [41:0] SENS_RND = 42'd127;

	logic                     v_s1, v_s2, v_s3;
	logic [RAW_W-1:0]         d1_s1, d1_s2, d1_s3;
	logic signed [24:0]       dt_s1;
	logic signed [41:0]       p6_s2, p4_s2, p3_s2;
	logic signed [TEMP_W-1:0] temp_s3;
	logic signed [OFF_W-1:0]  off_s3;
	logic signed [SENS_W-1:0] sens_s3;

	logic [41:0] p6_adj, p4_adj, p3_adj;
	logic [35:0] off_div;
	logic [34:0] sens_div;

	// bias negative products so the shift truncates toward zero
	assign p6_adj   = p6_s2 + (p6_s2[41] ? TEMP_RND : 42'd0);
	assign p4_adj   = p4_s2 + (p4_s2[41] ? OFF_RND : 42'd0);
	assign p3_adj   = p3_s2 + (p3_s2[41] ? SENS_RND : 42'd0);
	assign off_div  = p4_adj[41:6];
	assign sens_div = p3_adj[41:7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d1_s1   <= raw_pressure;
			dt_s1   <= $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.tref, 8'h00});
			d1_s2   <= d1_s1;
			p6_s2   <= dt_s1 * $signed({1'b0, cal.tempsens});
			p4_s2   <= dt_s1 * $signed({1'b0, cal.off_tc});
			p3_s2   <= dt_s1 * $signed({1'b0, cal.sens_tc});
			d1_s3   <= d1_s2;
			temp_s3 <= $signed(p6_adj[41:23]) + 19'sd2000;
			off_s3  <= $signed({4'b0, cal.off, 17'b0}) + $signed({off_div[35], off_div});
			sens_s3 <= $signed({4'b0, cal.sens, 16'b0}) + $signed({sens_div[34], sens_div});
		end
	end

	assign coef.valid        = v_s3;
	assign coef.raw_pressure = d1_s3;
	assign coef.temperature  = temp_s3;
	assign coef.off          = off_s3;
	assign coef.sens         = sens_s3;

endmodule
`default_nettype wire

>>> rtl/core/bpt_pres_pipe.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bpt_pres_pipe
// stages 4 to 7: split pressure product, offset removal and final scaling
// ----------------------------------------------------------------------------
module bpt_pres_pipe (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  bpt_pkg::coef_t                     coef,
	output logic                               out_valid,
	output logic signed [bpt_pkg::TEMP_W-1:0]  temperature,
	output logic signed [bpt_pkg::PRES_W-1:0]  pressure
);
	import bpt_pkg::*;

	localparam logic [59:0] PROD_RND = 60'h1F_FFFF;
	localparam logic [39:0] DIFF_RND = 40'h00_0000_7FFF;

	logic                     v_s4, v_s5, v_s6, v_s7;
	logic signed [TEMP_W-1:0] temp_s4, temp_s5, temp_s6, temp_s7;
	logic signed [OFF_W-1:0]  off_s4, off_s5;
	logic [41:0]              pp_lo_s4;
	logic signed [42:0]       pp_hi_s4;
	logic signed [59:0]       prod_s5;
	logic signed [39:0]       diff_s6;
	logic signed [PRES_W-1:0] pres_s7;

	logic [60:0] prod_sum;
	logic [59:0] prod_adj;
	logic [38:0] prod_div;
	logic [39:0] diff_adj;
	logic [24:0] pres_div;

	assign prod_sum = {pp_hi_s4, 18'b0} + {19'b0, pp_lo_s4};
	assign prod_adj = prod_s5 + (prod_s5[59] ? PROD_RND : 60'd0);
	assign prod_div = prod_adj[59:21];
	assign diff_adj = diff_s6 + (diff_s6[39] ? DIFF_RND : 40'd0);
	assign pres_div = diff_adj[39:15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s4 <= coef.valid;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// sensitivity split into an unsigned low and a signed high part
			pp_lo_s4 <= coef.raw_pressure * coef.sens[17:0];
			pp_hi_s4 <= $signed({1'b0, coef.raw_pressure}) * $signed(coef.sens[35:18]);
			temp_s4  <= coef.temperature;
			off_s4   <= coef.off;
			prod_s5  <= prod_sum[59:0];
			temp_s5  <= temp_s4;
			off_s5   <= off_s4;
			diff_s6  <= $signed({prod_div[38], prod_div}) - $signed({{3{off_s5[36]}}, off_s5});
			temp_s6  <= temp_s5;
			// quotient fits 25 bits, so it never reaches the 32-bit limits
			pres_s7  <= $signed({{7{pres_div[24]}}, pres_div});
			temp_s7  <= temp_s6;
		end
	end

	assign out_valid   = v_s7;
	assign temperature = temp_s7;
	assign pressure    = pres_s7;

endmodule
`default_nettype wire

>>> rtl/core/baro_pressure_temp_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_pressure_temp_compensation
// first-order compensation of raw barometric pressure and temperature
// ----------------------------------------------------------------------------
// conv carries one request per pair of raw 24-bit pressure and temperature
// conversions; result returns the temperature in hundredths of a degree and
// the compensated pressure. cfg writes the six calibration words by index
// 0 to 5; other indexes are dropped. cfg is always ready; the user must write
// the words only while no request is in flight, the block does not enforce it.
// one request is accepted every cycle unless a result waits untaken;
// the seven-stage pipeline and its split 24x36 pressure multiply set that rate.
// the result sits in the last pipeline register; while it is not taken the
// whole pipeline holds and conv.ready is low, so nothing is lost or repeated.
// reset clears all calibration words to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module baro_pressure_temp_compensation (
	input  logic        clk,
	input  logic        arst_n,
	bpt_conv_if.sink    conv,
	bpt_result_if.source result,
	bpt_cfg_if.sink     cfg
);
	import bpt_pkg::*;

	cal_t  cal;
	coef_t coef;
	logic  en;
	logic  res_valid;

	// advance unless a finished result is still waiting
	assign en         = !res_valid || result.ready;
	assign conv.ready = en;
	assign result.valid = res_valid;

	bpt_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cal    (cal)
	);

	bpt_coeff_pipe u_coeff (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.in_valid        (conv.valid),
		.raw_pressure    (conv.raw_pressure),
		.raw_temperature (conv.raw_temperature),
		.cal             (cal),
		.coef            (coef)
	);

	bpt_pres_pipe u_pres (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.coef        (coef),
		.out_valid   (res_valid),
		.temperature (result.temperature),
		.pressure    (result.pressure)
	);

endmodule
`default_nettype wire
